/* rtl/ovi_pkg.sv */
// Shared types and codes for the octree voxel path insert block.
package ovi_pkg;

	localparam int POS_W  = 18;
	localparam int ATTR_W = 56;
	localparam int CFG_W  = 5;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_RANGE    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_FULL     = 3'd4,
		ST_NODEPTH  = 3'd5
	} status_t;

	// What one level walk step found.
	typedef enum logic [2:0] {
		EV_PRESENT,
		EV_DFULL,
		EV_LEAF,
		EV_MISSING,
		EV_FOLLOW,
		EV_ALLOC
	} ev_t;

	typedef struct packed {
		logic    load;
		logic    append;
		logic    root;
		logic    rd;
		logic    ev;
		logic    alloc;
		logic    fin;
		logic    push;
		status_t fin_code;
	} ovi_cmd_t;

	typedef struct packed {
		logic bad_range;
		logic attr_full;
		logic no_root;
		logic no_depth;
		logic out_free;
		ev_t  outcome;
	} ovi_stat_t;

endpackage

/* rtl/octree_voxel_path_insert.sv */
// Top level of the octree voxel path insert block: config registers, controller, datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, pos_x/y/z, attr word    | input word
//  out     | out_valid/out_ready, status ... voxels     | result word
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata    | APB regs
//
// Walk: each level is a registered read of the descriptor, lookup, child-known
// and link memories (S_RD) followed by a read-modify-write (S_EV); a level that
// allocates a new descriptor adds a step that clears the fresh entry (S_ALLOC);
// depth <= 31. Rejected or no-depth words finish without a level walk.
// Reset: counters clear at once; no memory sweep, since every descriptor is
// cleared when it is allocated.
// Stalls: a result sits in the output register while the next word is taken;
// the walk waits only when a new result is ready and that register is still full.
module octree_voxel_path_insert import ovi_pkg::*; #(
	parameter int DESC_DEPTH = 1024,
	parameter int ATTR_DEPTH = 4096,
	parameter int COORD_BITS = 16,
	localparam int DW = $clog2(DESC_DEPTH),
	localparam int CW = $clog2(DESC_DEPTH + 1),
	localparam int AW = $clog2(ATTR_DEPTH),
	localparam int AC = $clog2(ATTR_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [POS_W-1:0]  pos_z,
	input  logic [ATTR_W-1:0] attribute_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [AW-1:0]     attribute_index,
	output logic [DW-1:0]     leaf_parent,
	output logic [CW-1:0]     descriptors_used,
	output logic [AC-1:0]     voxels_total,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// register map: word index from paddr[2]
	localparam logic REG_MAX_LEVELS   = 1'b0;
	localparam logic REG_BRICK_LEVELS = 1'b1;

	logic [CFG_W-1:0] max_levels_q;
	logic [CFG_W-1:0] brick_levels_q;
	ovi_cmd_t         cmd;
	ovi_stat_t        stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_levels_q   <= CFG_W'(12);
			brick_levels_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MAX_LEVELS:   max_levels_q   <= pwdata[CFG_W-1:0];
				REG_BRICK_LEVELS: brick_levels_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_LEVELS:   prdata = 32'(max_levels_q);
			REG_BRICK_LEVELS: prdata = 32'(brick_levels_q);
			default:          prdata = '0;
		endcase
	end

	ovi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	ovi_dp #(
		.DESC_DEPTH(DESC_DEPTH), .ATTR_DEPTH(ATTR_DEPTH), .COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.max_levels(max_levels_q), .brick_levels(brick_levels_q),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .attribute_word(attribute_word),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.attribute_index(attribute_index), .leaf_parent(leaf_parent),
		.descriptors_used(descriptors_used), .voxels_total(voxels_total)
	);

endmodule

/* rtl/ovi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ovi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ovi_ctrl.sv */
// Controller state machine sequencing one insert through the datapath.
module ovi_ctrl import ovi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ovi_stat_t stat,
	output ovi_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ROOT,
		S_DEPTH,
		S_RD,
		S_EV,
		S_ALLOC,
		S_OUT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		cmd.fin_code = ST_INSERTED;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.bad_range) begin
					cmd.fin = 1'b1;
					cmd.fin_code = ST_RANGE;
					state_d = S_OUT;
				end else if (stat.attr_full) begin
					cmd.fin = 1'b1;
					cmd.fin_code = ST_FULL;
					state_d = S_OUT;
				end else begin
					cmd.append = 1'b1;
					state_d = stat.no_root ? S_ROOT : S_DEPTH;
				end
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				state_d  = S_DEPTH;
			end
			S_DEPTH: begin
				if (stat.no_depth) begin
					cmd.fin = 1'b1;
					cmd.fin_code = ST_NODEPTH;
					state_d = S_OUT;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				unique case (stat.outcome)
					EV_PRESENT: begin
						cmd.fin = 1'b1;
						cmd.fin_code = ST_PRESENT;
						state_d = S_OUT;
					end
					EV_DFULL: begin
						cmd.fin = 1'b1;
						cmd.fin_code = ST_FULL;
						state_d = S_OUT;
					end
					EV_MISSING: begin
						cmd.fin = 1'b1;
						cmd.fin_code = ST_MISSING;
						state_d = S_OUT;
					end
					EV_LEAF: begin
						cmd.ev  = 1'b1;
						cmd.fin = 1'b1;
						cmd.fin_code = ST_INSERTED;
						state_d = S_OUT;
					end
					EV_FOLLOW: begin
						cmd.ev  = 1'b1;
						state_d = S_RD;
					end
					EV_ALLOC: begin
						cmd.ev  = 1'b1;
						state_d = S_ALLOC;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_RD;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	property p_fin_to_out;
		@(posedge clk) disable iff (!arst_n) cmd.fin |=> state_q == S_OUT;
	endproperty
	a_fin_to_out: assert property (p_fin_to_out) else $error("finish did not reach output");

	property p_rd_then_ev;
		@(posedge clk) disable iff (!arst_n) cmd.rd |=> state_q == S_EV;
	endproperty
	a_rd_then_ev: assert property (p_rd_then_ev) else $error("read not followed by eval");

	property p_load_idle;
		@(posedge clk) disable iff (!arst_n) cmd.load |-> in_ready;
	endproperty
	a_load_idle: assert property (p_load_idle) else $error("load outside idle");

endmodule

/* rtl/ovi_dp.sv */
// Datapath: input capture, descriptor/link/attribute memories, counters, result.
module ovi_dp import ovi_pkg::*; #(
	parameter int DESC_DEPTH = 1024,
	parameter int ATTR_DEPTH = 4096,
	parameter int COORD_BITS = 16,
	localparam int DW = $clog2(DESC_DEPTH),
	localparam int CW = $clog2(DESC_DEPTH + 1),
	localparam int AW = $clog2(ATTR_DEPTH),
	localparam int AC = $clog2(ATTR_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ovi_cmd_t          cmd,
	output ovi_stat_t         stat,
	input  logic [CFG_W-1:0]  max_levels,
	input  logic [CFG_W-1:0]  brick_levels,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [POS_W-1:0]  pos_z,
	input  logic [ATTR_W-1:0] attribute_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [AW-1:0]     attribute_index,
	output logic [DW-1:0]     leaf_parent,
	output logic [CW-1:0]     descriptors_used,
	output logic [AC-1:0]     voxels_total
);

	localparam int DESC_W = 16 + DW;
	localparam int LOOK_W = 8 + AW;

	logic [POS_W-1:0]  px_q, py_q, pz_q;
	logic [ATTR_W-1:0] word_q;
	logic [AW-1:0]     aidx_q;
	logic [DW-1:0]     cur_q;
	logic [CFG_W-1:0]  level_q;
	logic [2:0]        oct_q;
	status_t           res_code_q;
	logic [DW-1:0]     res_parent_q;
	logic [CW-1:0]     desc_count_q;
	logic [AC-1:0]     attr_count_q;
	logic [AC-1:0]     leaf_count_q;
	logic              out_valid_q;

	logic [DESC_W-1:0] desc_rd, desc_wd;
	logic [LOOK_W-1:0] look_rd, look_wd;
	logic [7:0]        known_rd, known_wd;
	logic [DW-1:0]     link_rd;
	logic [DW-1:0]     desc_wa, look_wa, known_wa;
	logic              desc_we, look_we, known_we, link_we, attr_we;
	logic [2:0]        oct_nx;
	logic [7:0]        bitm;
	logic [DW-1:0]     fresh;
	logic signed [CFG_W:0] depth;
	logic              last, exists;
	ev_t               outcome;
	logic [LOOK_W-1:0] lk;

	function automatic logic cbit(input logic [POS_W-1:0] v, input logic [CFG_W-1:0] lvl);
		int   sh;
		logic b;
		sh = COORD_BITS - 1 - int'(lvl);
		b  = 1'b0;
		if (sh >= 0 && sh < POS_W) begin
			b = v[sh[4:0]];
		end
		return b;
	endfunction

	function automatic logic in_rng(input logic [POS_W-1:0] v);
		return !v[POS_W-1] && ((v[POS_W-2:0] >> COORD_BITS) == '0);
	endfunction

	assign oct_nx = {cbit(pz_q, level_q), cbit(py_q, level_q), cbit(px_q, level_q)};
	assign bitm   = 8'(1) << oct_q;
	assign fresh  = desc_count_q[DW-1:0];

	always_comb begin
		if (brick_levels != '0) begin
			depth = $signed({1'b0, max_levels}) - $signed({1'b0, brick_levels});
		end else begin
			depth = $signed({1'b0, max_levels});
		end
	end

	assign last   = ($signed({1'b0, level_q}) == depth - 6'sd1);
	assign exists = (desc_rd[7:0] & bitm) != '0;

	always_comb begin
		priority if (exists && last) begin
			outcome = EV_PRESENT;
		end else if (!exists && !last && desc_count_q >= CW'(DESC_DEPTH)) begin
			outcome = EV_DFULL;
		end else if (last) begin
			outcome = EV_LEAF;
		end else if (exists) begin
			outcome = ((known_rd & bitm) != '0) ? EV_FOLLOW : EV_MISSING;
		end else begin
			outcome = EV_ALLOC;
		end
	end

	assign stat.bad_range = !in_rng(px_q) || !in_rng(py_q) || !in_rng(pz_q);
	assign stat.attr_full = attr_count_q >= AC'(ATTR_DEPTH);
	assign stat.no_root   = desc_count_q == '0;
	assign stat.no_depth  = depth[CFG_W] || depth == '0;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.outcome   = outcome;

	// leaf lookup word: mask bit, pointer fixed on first leaf
	always_comb begin
		lk = look_rd | LOOK_W'(bitm);
		if (lk[8 +: AW] == '0 && aidx_q != '0) begin
			lk[8 +: AW] = aidx_q;
		end
	end

	// memory write steering
	always_comb begin
		desc_we  = 1'b0; desc_wa  = '0; desc_wd  = '0;
		look_we  = 1'b0; look_wa  = '0; look_wd  = '0;
		known_we = 1'b0; known_wa = '0; known_wd = '0;
		link_we  = cmd.ev && outcome == EV_ALLOC;
		attr_we  = cmd.append;
		if (cmd.root) begin
			desc_we = 1'b1; look_we = 1'b1; known_we = 1'b1;
		end
		if (cmd.alloc) begin
			desc_we = 1'b1; look_we = 1'b1; known_we = 1'b1;
			desc_wa = fresh; look_wa = fresh; known_wa = fresh;
		end
		if (cmd.ev && outcome == EV_LEAF) begin
			desc_we = 1'b1;
			desc_wa = cur_q;
			desc_wd = desc_rd | DESC_W'(bitm) | (DESC_W'(bitm) << 8);
			look_we = 1'b1;
			look_wa = cur_q;
			look_wd = lk;
		end
		if (cmd.ev && outcome == EV_ALLOC) begin
			desc_we  = 1'b1;
			desc_wa  = cur_q;
			desc_wd  = {fresh, desc_rd[15:8], desc_rd[7:0] | bitm};
			known_we = 1'b1;
			known_wa = cur_q;
			known_wd = known_rd | bitm;
		end
	end

	ovi_ram #(.WIDTH(DESC_W), .DEPTH(DESC_DEPTH)) u_desc (
		.clk(clk), .we(desc_we), .waddr(desc_wa), .wdata(desc_wd),
		.raddr(cur_q), .rdata(desc_rd)
	);

	ovi_ram #(.WIDTH(LOOK_W), .DEPTH(DESC_DEPTH)) u_look (
		.clk(clk), .we(look_we), .waddr(look_wa), .wdata(look_wd),
		.raddr(cur_q), .rdata(look_rd)
	);

	ovi_ram #(.WIDTH(8), .DEPTH(DESC_DEPTH)) u_known (
		.clk(clk), .we(known_we), .waddr(known_wa), .wdata(known_wd),
		.raddr(cur_q), .rdata(known_rd)
	);

	ovi_ram #(.WIDTH(DW), .DEPTH(DESC_DEPTH * 8)) u_link (
		.clk(clk), .we(link_we), .waddr({cur_q, oct_q}), .wdata(fresh),
		.raddr({cur_q, oct_nx}), .rdata(link_rd)
	);

	logic [ATTR_W-1:0] attr_unused_rd;

	ovi_ram #(.WIDTH(ATTR_W), .DEPTH(ATTR_DEPTH)) u_attr (
		.clk(clk), .we(attr_we), .waddr(attr_count_q[AW-1:0]), .wdata(word_q),
		.raddr(attr_count_q[AW-1:0]), .rdata(attr_unused_rd)
	);

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			pz_q    <= pos_z;
			word_q  <= attribute_word;
			aidx_q  <= '0;
			cur_q   <= '0;
			level_q <= '0;
		end
		if (cmd.append) begin
			aidx_q <= attr_count_q[AW-1:0];
		end
		if (cmd.rd) begin
			oct_q <= oct_nx;
		end
		if (cmd.ev && outcome == EV_FOLLOW) begin
			cur_q   <= link_rd;
			level_q <= level_q + 1'b1;
		end
		if (cmd.alloc) begin
			cur_q   <= fresh;
			level_q <= level_q + 1'b1;
		end
		if (cmd.fin) begin
			res_code_q   <= cmd.fin_code;
			res_parent_q <= (cmd.fin_code == ST_INSERTED || cmd.fin_code == ST_PRESENT)
				? cur_q : '0;
		end
		if (cmd.push) begin
			status           <= res_code_q;
			attribute_index  <= aidx_q;
			leaf_parent      <= res_parent_q;
			descriptors_used <= desc_count_q;
			voxels_total     <= leaf_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_count_q <= '0;
			attr_count_q <= '0;
			leaf_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.append) begin
				attr_count_q <= attr_count_q + 1'b1;
			end
			if (cmd.root) begin
				desc_count_q <= CW'(1);
			end
			if (cmd.alloc) begin
				desc_count_q <= desc_count_q + 1'b1;
			end
			if (cmd.ev && outcome == EV_LEAF) begin
				leaf_count_q <= leaf_count_q + 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	property p_desc_bound;
		@(posedge clk) disable iff (!arst_n) desc_count_q <= CW'(DESC_DEPTH);
	endproperty
	a_desc_bound: assert property (p_desc_bound) else $error("descriptor count overflow");

	property p_leaf_le_attr;
		@(posedge clk) disable iff (!arst_n) leaf_count_q <= attr_count_q;
	endproperty
	a_leaf_le_attr: assert property (p_leaf_le_attr) else $error("more leaves than attributes");

	property p_alloc_room;
		@(posedge clk) disable iff (!arst_n) cmd.alloc |-> desc_count_q < CW'(DESC_DEPTH);
	endproperty
	a_alloc_room: assert property (p_alloc_room) else $error("alloc with full store");

	property p_push_free;
		@(posedge clk) disable iff (!arst_n) cmd.push |-> stat.out_free;
	endproperty
	a_push_free: assert property (p_push_free) else $error("push over pending word");

endmodule

/* verif/testbench.sv */
// Testbench for the octree voxel path insert block: directed table, phased random, scoreboard.
`timescale 1ns / 100ps

module testbench;
	import ovi_pkg::*;

	localparam int NODES     = 1024;
	localparam int SLOTS     = 4096;
	localparam int LIMIT     = 3000000;
	localparam int REG_MAX_LEVELS   = 0;
	localparam int REG_BRICK_LEVELS = 1;

	// one result word
	typedef struct {
		status_t     code;
		logic [11:0] slot;
		logic [9:0]  parent;
		logic [10:0] nodes_used;
		logic [12:0] leaves;
	} insert_result_t;

	// one row of the directed table; typed rows carry their answer
	typedef struct {
		logic [17:0]    x, y, z;
		logic [55:0]    word;
		bit             typed;
		insert_result_t answer;
	} vector_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [17:0]       pos_x = '0, pos_y = '0, pos_z = '0;
	logic [55:0]       attribute_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [11:0]       attribute_index;
	logic [9:0]        leaf_parent;
	logic [10:0]       descriptors_used;
	logic [12:0]       voxels_total;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	octree_voxel_path_insert dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Octree shadow: only the valid masks, link bits and links steer the walk,
	// so leaf masks and lookup words are not kept.
	// --------------------------------------------------------------------
	logic [7:0]  valid_mask [NODES];
	logic [7:0]  link_known [NODES];
	logic [9:0]  link_to    [NODES*8];
	int unsigned node_count, slot_count, leaf_count;
	logic [4:0]  levels_cfg = 5'd12, brick_cfg = 5'd0;

	insert_result_t pending[$];
	int   errors = 0;
	int   words_sent = 0;
	bit   quiet = 1'b0;      // no idling on either side
	bit   long_hold_done = 1'b0;
	logic [15:0] base_x, base_y, base_z;

	function automatic insert_result_t pack_result(status_t c, int s, int p);
		insert_result_t r;
		r.code = c;
		r.slot = s[11:0];
		r.parent = p[9:0];
		r.nodes_used = node_count[10:0];
		r.leaves = leaf_count[12:0];
		return r;
	endfunction

	function automatic insert_result_t insert_voxel(logic [17:0] x, y, z);
		int   slot, depth, lvl, cur, fresh;
		logic [2:0] oct;
		logic [7:0] bitm;
		bit   exists, last;
		// anything negative or at/above 2^16 is rejected untouched
		if (x[17:16] != 2'b00 || y[17:16] != 2'b00 || z[17:16] != 2'b00)
			return pack_result(ST_RANGE, 0, 0);
		if (slot_count >= SLOTS)
			return pack_result(ST_FULL, 0, 0);
		slot = slot_count;
		slot_count++;
		if (node_count == 0) begin
			valid_mask[0] = '0;
			link_known[0] = '0;
			node_count = 1;
		end
		depth = (brick_cfg != 0) ? int'(levels_cfg) - int'(brick_cfg) : int'(levels_cfg);
		if (depth <= 0)
			return pack_result(ST_NODEPTH, slot, 0);
		cur = 0;
		for (lvl = 0; lvl < depth; lvl++) begin
			// below the coordinate resolution the octant is always zero
			oct = (lvl < 16) ? {z[15-lvl], y[15-lvl], x[15-lvl]} : 3'd0;
			bitm = 8'd1 << oct;
			last = (lvl == depth - 1);
			exists = (valid_mask[cur] & bitm) != 0;
			if (exists && last)
				return pack_result(ST_PRESENT, slot, cur);
			if (!exists && !last && node_count >= NODES)
				return pack_result(ST_FULL, slot, 0);
			valid_mask[cur] |= bitm;
			if (last) begin
				leaf_count++;
				return pack_result(ST_INSERTED, slot, cur);
			end
			if (exists) begin
				// a leaf octant has no child to descend into
				if ((link_known[cur] & bitm) == 0)
					return pack_result(ST_MISSING, slot, 0);
				cur = link_to[cur*8 + oct];
			end else begin
				fresh = node_count;
				link_to[cur*8 + oct] = fresh[9:0];
				link_known[cur] |= bitm;
				valid_mask[fresh] = '0;
				link_known[fresh] = '0;
				node_count++;
				cur = fresh;
			end
		end
		return pack_result(ST_NODEPTH, slot, 0);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// --------------------------------------------------------------------
	// Result checker: every accepted result word against the oldest prediction.
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		insert_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected result word", status, -1);
			end else begin
				e = pending.pop_front();
				if (status != e.code)            report_mismatch("status", status, e.code);
				if (attribute_index != e.slot)   report_mismatch("attribute_index",
					attribute_index, e.slot);
				if (leaf_parent != e.parent)     report_mismatch("leaf_parent", leaf_parent,
					e.parent);
				if (descriptors_used != e.nodes_used) report_mismatch("descriptors_used",
					descriptors_used, e.nodes_used);
				if (voxels_total != e.leaves)    report_mismatch("voxels_total", voxels_total,
					e.leaves);
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off once traffic runs so
	// the block backs up and drops in_ready while words keep being offered.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && words_sent >= 300) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 9);
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog.
	initial begin
		int cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// APB write: setup then access; also updates the shadow config.
	task automatic reg_write(int idx, logic [4:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(4 * idx); pwdata <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_MAX_LEVELS) levels_cfg = value;
		else if (idx == REG_BRICK_LEVELS) brick_cfg = value;
	endtask

	// Offer one word and hold it until taken; valid stays up for the caller unless a random idle gap drops it.
	task automatic push_word(logic [17:0] x, y, z, logic [55:0] w, bit typed,
		insert_result_t answer);
		insert_result_t p;
		in_valid <= 1'b1;
		pos_x <= x; pos_y <= y; pos_z <= z; attribute_word <= w;
		do @(posedge clk); while (!in_ready);
		p = insert_voxel(x, y, z);
		pending.insert(pending.size(), typed ? answer : p);
		words_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Block is idle once every result is back; leave margin for the last walk.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Mostly clustered positions sharing a path, some uniform, some junk.
	task automatic random_words(int count);
		logic [15:0] mask;
		logic [17:0] x, y, z;
		int r;
		insert_result_t none;
		none = '{ST_INSERTED, 0, 0, 0, 0};
		base_x = $urandom; base_y = $urandom; base_z = $urandom;
		repeat (count) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				mask = 16'((32'd1 << $urandom_range(0, 10)) - 1);
				x = {2'b00, base_x ^ (16'($urandom) & mask)};
				y = {2'b00, base_y ^ (16'($urandom) & mask)};
				z = {2'b00, base_z ^ (16'($urandom) & mask)};
			end else if (r < 9) begin
				x = {2'b00, 16'($urandom)};
				y = {2'b00, 16'($urandom)};
				z = {2'b00, 16'($urandom)};
			end else begin
				x = 18'($urandom); y = 18'($urandom); z = 18'($urandom);
			end
			push_word(x, y, z, {24'($urandom), 32'($urandom)}, 1'b0, none);
		end
	endtask

	vector_row_t rows[$];

	initial begin
		int k;
		int phase_levels [10] = '{4, 8, 16, 17, 12, 3, 16, 10, 14, 31};
		int phase_bricks [10] = '{0, 2, 0, 0, 11, 5, 16, 0, 1, 0};
		int phase_words  [10] = '{120, 150, 150, 100, 80, 40, 40, 200, 200, 120};
		insert_result_t none;
		none = '{ST_INSERTED, 0, 0, 0, 0};
		for (k = 0; k < NODES; k++) begin
			valid_mask[k] = '0;
			link_known[k] = '0;
		end
		node_count = 0; slot_count = 0; leaf_count = 0;

		// Directed table at the reset depth of 12. The first path from the
		// origin allocates 11 descriptors below the root, so its leaf lands in 11.
		rows = '{
			'{18'h00000, 18'h00000, 18'h00000, 56'h0, 1, '{ST_INSERTED, 0, 11, 12, 1}},
			'{18'h00000, 18'h00000, 18'h00000, {56{1'b1}}, 1, '{ST_PRESENT, 1, 11, 12, 1}},
			'{18'h3FFFF, 18'h00000, 18'h00000, 56'h1, 1, '{ST_RANGE, 0, 0, 12, 1}},
			'{18'h00000, 18'h10000, 18'h00000, 56'h2, 1, '{ST_RANGE, 0, 0, 12, 1}},
			'{18'h00000, 18'h00000, 18'h20000, 56'h3, 1, '{ST_RANGE, 0, 0, 12, 1}},
			'{18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 56'h4, 1, '{ST_RANGE, 0, 0, 12, 1}},
			// far corner shares only the root: 11 more descriptors
			'{18'h0FFFF, 18'h0FFFF, 18'h0FFFF, 56'hA5A5A5A5A5A5A5, 1,
				'{ST_INSERTED, 2, 22, 23, 2}},
			'{18'h0FFFF, 18'h00000, 18'h00000, 56'h5A5A5A5A5A5A5A, 0, none},
			'{18'h00000, 18'h0FFFF, 18'h00000, 56'h123456789ABCDE, 0, none},
			'{18'h00000, 18'h00000, 18'h0FFFF, 56'hFEDCBA98765432, 0, none},
			// low bits below the walked depth: same leaf
			'{18'h00001, 18'h00000, 18'h0000F, 56'h7, 0, none},
			// differs at the last walked level only: sibling leaf
			'{18'h00010, 18'h00000, 18'h00000, 56'h8, 0, none},
			'{18'h08000, 18'h08000, 18'h00000, 56'h9, 0, none},
			'{18'h05555, 18'h0AAAA, 18'h01234, 56'hFF00FF00FF00FF, 0, none},
			'{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 56'hFFFFFFFFFFFFFF, 0, none}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			push_word(rows[i].x, rows[i].y, rows[i].z, rows[i].word, rows[i].typed,
				rows[i].answer);
		drain();

		// Random phases across depths: shallow, beyond coordinate bits, a single
		// level, negative and zero depth, and the largest field value. Depth
		// changes make later deep paths run into leaf octants (missing link) and
		// the descriptor store eventually runs out.
		for (k = 0; k < 10; k++) begin
			reg_write(REG_MAX_LEVELS, 5'(phase_levels[k]));
			reg_write(REG_BRICK_LEVELS, 5'(phase_bricks[k]));
			random_words(phase_words[k]);
			drain();
		end

		// Last stretch at the reset depth, back to back with no idling.
		quiet = 1'b1;
		reg_write(REG_MAX_LEVELS, 5'd12);
		reg_write(REG_BRICK_LEVELS, 5'd0);
		random_words(140);
		drain();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
